@@ design/fdmm_pkg.sv @@
// Shared constants and types for the frame-difference motion mask.
`default_nettype none

package fdmm_pkg;

  localparam int MAX_PIXELS  = 65536;
  localparam int ADDR_W      = $clog2(MAX_PIXELS);
  localparam int PIX_W       = 8;
  localparam int WEIGHT_W    = 14;
  localparam int GRAY_SHIFT  = 14;
  localparam int ACC_W       = 22;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [WEIGHT_W-1:0] W_BLUE     = WEIGHT_W'(1868);
  localparam logic [WEIGHT_W-1:0] W_GREEN    = WEIGHT_W'(9617);
  localparam logic [WEIGHT_W-1:0] W_RED      = WEIGHT_W'(4899);
  localparam logic [ACC_W-1:0]    GRAY_ROUND = ACC_W'(8192);
  localparam logic [ADDR_W-1:0]   LAST_ADDR  = ADDR_W'(MAX_PIXELS - 1);

  // One gray-converted pixel on its way from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  red;
    logic              frame_end;
    logic              first;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  gray;
  } fdmm_item_t;

endpackage

`default_nettype wire

@@ design/fdmm_front.sv @@
// Front end: accepts pixels, tracks position and first frame, computes gray.
`default_nettype none

module fdmm_front import fdmm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_blue,
  input  wire logic [PIX_W-1:0] in_green,
  input  wire logic [PIX_W-1:0] in_red,
  input  wire logic             in_frame_end,
  output logic                  q_push,
  output fdmm_item_t            q_item,
  input  wire logic             q_full
);

  logic              s_valid_r;
  logic [PIX_W-1:0]  s_blue_r, s_green_r, s_red_r;
  logic [ACC_W-1:0]  s_pb_r, s_pg_r, s_pr_r;
  logic              s_fe_r;
  logic              s_first_r;
  logic [ADDR_W-1:0] s_addr_r;

  logic [ADDR_W-1:0] pixel_index_r, pixel_index_nxt;
  logic              first_frame_r;
  logic              accept;
  logic [ACC_W-1:0]  acc;

  assign in_ready = !s_valid_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = s_valid_r && !q_full;

  always_comb begin
    if (in_frame_end) begin
      pixel_index_nxt = '0;
    end else if (pixel_index_r != LAST_ADDR) begin
      pixel_index_nxt = pixel_index_r + ADDR_W'(1);
    end else begin
      pixel_index_nxt = pixel_index_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r     <= 1'b0;
      pixel_index_r <= '0;
      first_frame_r <= 1'b1;
    end else begin
      if (accept) begin
        s_valid_r     <= 1'b1;
        pixel_index_r <= pixel_index_nxt;
        if (in_frame_end) begin
          first_frame_r <= 1'b0;
        end
      end else if (q_push) begin
        s_valid_r <= 1'b0;
      end
    end
  end

  // Constant-weight products, registered ahead of the sum.
  always_ff @(posedge clk) begin
    if (accept) begin
      s_blue_r  <= in_blue;
      s_green_r <= in_green;
      s_red_r   <= in_red;
      s_fe_r    <= in_frame_end;
      s_first_r <= first_frame_r;
      s_addr_r  <= pixel_index_r;
      s_pb_r    <= ACC_W'(in_blue)  * ACC_W'(W_BLUE);
      s_pg_r    <= ACC_W'(in_green) * ACC_W'(W_GREEN);
      s_pr_r    <= ACC_W'(in_red)   * ACC_W'(W_RED);
    end
  end

  assign acc = s_pb_r + s_pg_r + s_pr_r + GRAY_ROUND;

  always_comb begin
    q_item.blue      = s_blue_r;
    q_item.green     = s_green_r;
    q_item.red       = s_red_r;
    q_item.frame_end = s_fe_r;
    q_item.first     = s_first_r;
    q_item.addr      = s_addr_r;
    q_item.gray      = acc[GRAY_SHIFT +: PIX_W];
  end

endmodule

`default_nettype wire

@@ design/fdmm_fifo.sv @@
// Short queue between the front end and the back end.
`default_nettype none

module fdmm_fifo import fdmm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire fdmm_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output fdmm_item_t      pop_item,
  output logic            empty
);

  fdmm_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ design/fdmm_back.sv @@
// Back end: previous-frame gray store, difference test and output register.
`default_nettype none

module fdmm_back import fdmm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [PIX_W-1:0] threshold,
  input  wire fdmm_item_t       q_item,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      out_blue,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_red,
  output logic                  out_motion,
  output logic                  out_frame_end
);

  logic [PIX_W-1:0] gray_mem [MAX_PIXELS];
  logic [PIX_W-1:0] old_gray_r;

  logic             a_valid_r;
  fdmm_item_t       a_item_r;
  logic             o_valid_r;
  logic             a_advance;
  logic [PIX_W-1:0] diff;
  logic             moving;

  // First-frame pixels leave stage A without a result.
  assign a_advance = a_valid_r && (a_item_r.first || !o_valid_r || out_ready);
  assign q_pop     = !q_empty && (!a_valid_r || a_advance);

  assign diff   = (a_item_r.gray > old_gray_r) ? (a_item_r.gray - old_gray_r)
                                               : (old_gray_r - a_item_r.gray);
  assign moving = diff > threshold;

  // Read old gray and write new gray at the same address in one access.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      old_gray_r              <= gray_mem[q_item.addr];
      gray_mem[q_item.addr]   <= q_item.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        a_valid_r <= 1'b1;
      end else if (a_advance) begin
        a_valid_r <= 1'b0;
      end
      if (a_advance && !a_item_r.first) begin
        o_valid_r <= 1'b1;
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_item_r <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance && !a_item_r.first) begin
      out_blue      <= moving ? a_item_r.blue  : '0;
      out_green     <= moving ? a_item_r.green : '0;
      out_red       <= moving ? a_item_r.red   : '0;
      out_motion    <= moving;
      out_frame_end <= a_item_r.frame_end;
    end
  end

  assign out_valid = o_valid_r;

endmodule

`default_nettype wire

@@ design/frame_difference_motion_mask.sv @@
// Top level of the frame-difference motion mask.
`default_nettype none

// Takes one BGR pixel per clock in raster order, with in_frame_end on the
// last pixel of each frame, converts it to 8-bit gray (BT.601 weights,
// 14-bit fixed point, rounded) and compares it with the gray stored for the
// same position in the previous frame. A pixel whose gray differs by more
// than the threshold passes unchanged with out_motion set; any other pixel
// comes out black with out_motion clear. The first frame after reset only
// fills the store and gives no transfers. Positions past the store size
// share its last entry. Sustained rate is one pixel per clock while
// out_ready stays high. From input transfer to out_valid, the product
// register feeds the four-entry queue, the registered read of the 64K x 8
// gray store follows, and the output register ends the path. Write
// cfg_threshold only while no pixel is in flight.
module frame_difference_motion_mask import fdmm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [PIX_W-1:0] cfg_threshold,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_blue,
  input  wire logic [PIX_W-1:0] in_green,
  input  wire logic [PIX_W-1:0] in_red,
  input  wire logic             in_frame_end,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      out_blue,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_red,
  output logic                  out_motion,
  output logic                  out_frame_end
);

  logic [PIX_W-1:0] threshold_r;
  logic             push, full, pop, empty;
  fdmm_item_t       push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_threshold;
    end
  end

  fdmm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_blue      (in_blue),
    .in_green     (in_green),
    .in_red       (in_red),
    .in_frame_end (in_frame_end),
    .q_push       (push),
    .q_item       (push_item),
    .q_full       (full)
  );

  fdmm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  fdmm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .threshold     (threshold_r),
    .q_item        (pop_item),
    .q_empty       (empty),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_motion    (out_motion),
    .out_frame_end (out_frame_end)
  );

endmodule

`default_nettype wire
